// ===== sv/bht_pkg.sv =====
package bht_pkg;

  // Table geometry
  localparam int unsigned BUCKETS  = 256;
  localparam int unsigned WAYS     = 4;
  localparam int unsigned KEY_BITS = 64;
  localparam int unsigned ENTRIES  = BUCKETS * WAYS;

  // Field widths
  localparam int unsigned TAXA_W = 7;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned ST_W   = 2;

  // Derived widths
  localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(WAYS + 1);

  // Hash bits folded per cycle
  localparam int unsigned STEP = (KEY_BITS < 4) ? KEY_BITS : 4;

  // Stream packing
  localparam int unsigned IN_TDATA_W  = ((KEY_BITS + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = OUT_W;
  localparam int unsigned OUT_TUSER_W = 1 + ST_W;

  // Request kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_PUT    = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_NEW  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Write control toward the entry store
  typedef struct packed {
    logic             key_en;
    logic             val_en;
    logic [ENT_W-1:0] addr;
  } ent_wr_t;

endpackage

// ===== sv/bipartition_hash_table.sv =====
// One transaction at a time: the hash folds 4 taxa per cycle, then the scan reads and
// compares the ways of the bucket in turn, at most the bucket fill (up to 4).
// Reset: taxa count returns to 64, every bucket reads as empty; key and value
// memories are not cleared.
module bipartition_hash_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel: taxa_in_use
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bht_pkg::TAXA_W-1:0]         cfg_data_i,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key, new_value, zero pad
  input  logic                               s_axis_tuser,  // kind
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // stored_value
  output logic [bht_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // found, status
);
  import bht_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_FILL = 6'b000100,
    S_RD   = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [TAXA_W-1:0]   taxa_q, taxa_n;
  logic                kind_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]    nv_q;
  logic [BKT_W-1:0]    bkt_q;
  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W-1:0]   w_q;
  logic                hit_q;
  logic [VAL_W-1:0]    hit_val_q;

  logic                out_vld_q, out_found_q;
  logic [OUT_W-1:0]    out_val_q;
  logic [ST_W-1:0]     out_st_q;

  logic                in_fire, out_load;
  logic                hash_done;
  logic [BKT_W-1:0]    hash_bkt;
  logic [FILL_W-1:0]   fill_rd;
  logic [KEY_BITS-1:0] ent_key, mask, diff;
  logic [VAL_W-1:0]    ent_val;
  logic                match;
  logic [ENT_W-1:0]    ent_addr;
  logic                fill_wr_en, ent_rd_en;
  ent_wr_t             ent_wr;
  logic                found_d;
  logic [OUT_W-1:0]    val_d;
  logic [ST_W-1:0]     st_d;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

  // Saturate the taxa count and build the compare mask
  assign taxa_n = (taxa_q > TAXA_W'(KEY_BITS)) ? TAXA_W'(KEY_BITS) : taxa_q;

  always_comb begin
    for (int b = 0; b < KEY_BITS; b++) begin
      mask[b] = TAXA_W'(b) < taxa_n;
    end
  end

  // Match the key itself or its complement
  assign diff  = ent_key ^ key_q;
  assign match = ((diff & mask) == '0) || ((~diff & mask) == '0);

  assign ent_addr = ENT_W'(ENT_W'(bkt_q) * ENT_W'(WAYS)) + ENT_W'(w_q);

  bht_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .key_i    (s_axis_tdata[KEY_BITS-1:0]),
    .taxa_i   (taxa_n),
    .done_o   (hash_done),
    .bucket_o (hash_bkt)
  );

  bht_fill u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (hash_done),
    .rd_addr_i (hash_bkt),
    .rd_data_o (fill_rd),
    .wr_en_i   (fill_wr_en),
    .wr_addr_i (bkt_q),
    .wr_data_i (fill_q + 1'b1)
  );

  assign ent_rd_en = (state_q == S_RD) && (w_q < fill_q);

  bht_entry u_entry (
    .clk_i     (clk_i),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (ent_addr),
    .rd_key_o  (ent_key),
    .rd_val_o  (ent_val),
    .wr_i      (ent_wr),
    .wr_key_i  (key_q),
    .wr_val_i  (nv_q)
  );

  // Decide the result and the write-back
  always_comb begin
    found_d       = hit_q;
    val_d         = hit_q ? {1'b0, hit_val_q} : '1;
    st_d          = ST_OK;
    fill_wr_en    = 1'b0;
    ent_wr.key_en = 1'b0;
    ent_wr.val_en = 1'b0;
    ent_wr.addr   = ent_addr;
    if (kind_q == KIND_PUT) begin
      if (hit_q) begin
        ent_wr.val_en = out_load;
      end else if (fill_q < FILL_W'(WAYS)) begin
        st_d          = ST_NEW;
        ent_wr.key_en = out_load;
        ent_wr.val_en = out_load;
        fill_wr_en    = out_load;
      end else begin
        st_d = ST_FULL;
      end
    end
  end

  // Sequence one transaction
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_HASH;
      S_HASH: if (hash_done) state_d = S_FILL;
      S_FILL: state_d = S_RD;
      S_RD:   state_d = (w_q < fill_q) ? S_CMP : S_DONE;
      S_CMP:  state_d = match ? S_DONE : S_RD;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      taxa_q    <= TAXA_W'(KEY_BITS);
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        taxa_q <= cfg_data_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the request and the scan progress
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[KEY_BITS-1:0];
      nv_q   <= s_axis_tdata[KEY_BITS +: VAL_W];
    end
    if (hash_done) begin
      bkt_q <= hash_bkt;
    end
    if (state_q == S_FILL) begin
      fill_q <= fill_rd;
      w_q    <= '0;
      hit_q  <= 1'b0;
    end
    if (state_q == S_CMP) begin
      if (match) begin
        hit_q     <= 1'b1;
        hit_val_q <= ent_val;
      end else begin
        w_q <= w_q + 1'b1;
      end
    end
    if (out_load) begin
      out_found_q <= found_d;
      out_val_q   <= val_d;
      out_st_q    <= st_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = {out_st_q, out_found_q};

  // A hit never reports a status other than ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == ST_OK)
    else $error("found result with non-ok status");

  // The scan only compares ways below the bucket fill
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> w_q < fill_q)
    else $error("way compare beyond bucket fill");

  // The hash unit finishes only while a transaction waits on it
  a_hash_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> state_q == S_HASH)
    else $error("hash done outside hash phase");

  // An accepted request starts the hash phase next
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_HASH)
    else $error("accepted request did not start hashing");

endmodule

// ===== sv/bht_hash.sv =====
module bht_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bht_pkg::KEY_BITS-1:0]  key_i,
  input  logic [bht_pkg::TAXA_W-1:0]    taxa_i,
  output logic                          done_o,
  output logic [bht_pkg::BKT_W-1:0]     bucket_o
);
  import bht_pkg::*;

  logic                busy_q, done_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TAXA_W-1:0]   taxa_q, idx_q, ns_q, ns_d, nu;
  logic [HASH_W-1:0]   hs_q, hs_d, hu_q, hu_d, ha_q, ha_d, hash;
  logic                last;

  // Fold one chunk of taxon indices into the three running hashes
  always_comb begin
    logic [TAXA_W-1:0] pos;
    hs_d = hs_q;
    hu_d = hu_q;
    ha_d = ha_q;
    ns_d = ns_q;
    pos  = '0;
    for (int j = 0; j < STEP; j++) begin
      pos = idx_q + TAXA_W'(j);
      if (pos < taxa_q) begin
        if (key_q[j]) begin
          hs_d = (hs_d << 5) - hs_d + HASH_W'(pos);
          ns_d = ns_d + 1'b1;
        end else begin
          hu_d = (hu_d << 5) - hu_d + HASH_W'(pos);
        end
        ha_d = (ha_d << 5) - ha_d + HASH_W'(pos);
      end
    end
  end

  assign last = ({1'b0, idx_q} + (TAXA_W + 1)'(STEP)) >= {1'b0, taxa_q};

  // Sequence the fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the working values
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q  <= key_i;
      taxa_q <= taxa_i;
      idx_q  <= '0;
      hs_q   <= HASH_W'(1);
      hu_q   <= HASH_W'(1);
      ha_q   <= HASH_W'(1);
      ns_q   <= '0;
    end else if (busy_q) begin
      key_q <= key_q >> STEP;
      idx_q <= idx_q + TAXA_W'(STEP);
      hs_q  <= hs_d;
      hu_q  <= hu_d;
      ha_q  <= ha_d;
      ns_q  <= ns_d;
    end
  end

  // Pick the minority-side hash, all indices on a tie
  assign nu   = taxa_q - ns_q;
  assign hash = (ns_q == nu) ? ha_q : ((ns_q < nu) ? hs_q : hu_q);

  assign done_o   = done_q;
  assign bucket_o = BKT_W'(hash & HASH_W'(BUCKETS - 1));

endmodule

// ===== sv/bht_fill.sv =====
module bht_fill (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [bht_pkg::BKT_W-1:0]   rd_addr_i,
  output logic [bht_pkg::FILL_W-1:0]  rd_data_o,
  input  logic                        wr_en_i,
  input  logic [bht_pkg::BKT_W-1:0]   wr_addr_i,
  input  logic [bht_pkg::FILL_W-1:0]  wr_data_i
);
  import bht_pkg::*;

  logic [FILL_W-1:0]  mem_q [BUCKETS];
  logic [BUCKETS-1:0] vld_q;
  logic [FILL_W-1:0]  rd_q;
  logic               rd_vld_q;

  // Fill count storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: a bucket never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/bht_entry.sv =====
module bht_entry (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [bht_pkg::ENT_W-1:0]     rd_addr_i,
  output logic [bht_pkg::KEY_BITS-1:0]  rd_key_o,
  output logic [bht_pkg::VAL_W-1:0]     rd_val_o,
  input  bht_pkg::ent_wr_t              wr_i,
  input  logic [bht_pkg::KEY_BITS-1:0]  wr_key_i,
  input  logic [bht_pkg::VAL_W-1:0]     wr_val_i
);
  import bht_pkg::*;

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0]    val_mem [ENTRIES];
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]    val_q;

  // Key and value stores share one address per access
  always_ff @(posedge clk_i) begin
    if (wr_i.key_en) begin
      key_mem[wr_i.addr] <= wr_key_i;
    end
    if (wr_i.val_en) begin
      val_mem[wr_i.addr] <= wr_val_i;
    end
    if (rd_en_i) begin
      key_q <= key_mem[rd_addr_i];
      val_q <= val_mem[rd_addr_i];
    end
  end

  assign rd_key_o = key_q;
  assign rd_val_o = val_q;

endmodule

// ===== verif/split_table_monitor.sv =====
`timescale 1ns / 100ps

module split_table_monitor
  import bht_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [TAXA_W-1:0]      cfg_data_i,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [IN_TDATA_W-1:0]  req_data_i,   // key, new_value, zero pad
  input  logic                   req_kind_i,
  input  logic                   rsp_valid_i,
  input  logic                   rsp_ready_i,
  input  logic [OUT_TDATA_W-1:0] rsp_data_i,   // stored_value
  input  logic [OUT_TUSER_W-1:0] rsp_tuser_i,  // found, status
  output int unsigned            pending_o,
  output int unsigned            mismatches_o
);

  typedef struct packed {
    logic              found;
    logic [OUT_W-1:0]  value;
    logic [ST_W-1:0]   status;
  } reply_t;

  // Shadow copy of the table
  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0]    val_mem [ENTRIES];
  int unsigned         fill [BUCKETS];
  logic [TAXA_W-1:0]   taxa_reg = TAXA_W'(KEY_BITS);

  reply_t      replies_due [$];
  int unsigned mismatches = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Fold 31*h+i over the minority side of the split, over all taxa on a tie
  function automatic logic [HASH_W-1:0] split_hash(input logic [KEY_BITS-1:0] key,
                                                   input int unsigned n);
    logic [HASH_W-1:0] h_set, h_clr, h_all;
    int unsigned n_set, n_clr;
    h_set = 1;
    h_clr = 1;
    h_all = 1;
    n_set = 0;
    n_clr = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (key[i]) begin
        h_set = 31 * h_set + HASH_W'(i);
        n_set++;
      end else begin
        h_clr = 31 * h_clr + HASH_W'(i);
        n_clr++;
      end
      h_all = 31 * h_all + HASH_W'(i);
    end
    if (n_set == n_clr) return h_all;
    return (n_set < n_clr) ? h_set : h_clr;
  endfunction

  // Look the key up, apply a put, and return the reply it should produce
  function automatic reply_t predict_reply(input logic kind, input logic [KEY_BITS-1:0] key,
                                           input logic [VAL_W-1:0] new_val);
    int unsigned n, bkt, base, used, hit;
    logic [KEY_BITS-1:0] mask;
    reply_t r;
    n    = (taxa_reg > KEY_BITS) ? KEY_BITS : taxa_reg;
    mask = (n >= KEY_BITS) ? '1 : ((KEY_BITS'(1) << n) - KEY_BITS'(1));
    bkt  = split_hash(key, n) & (BUCKETS - 1);
    base = bkt * WAYS;
    used = fill[bkt];
    hit  = WAYS;
    for (int unsigned w = 0; w < used; w++) begin
      if (hit == WAYS && ((((key_mem[base + w] ^ key) & mask) == '0) ||
                          (((key_mem[base + w] ^ ~key) & mask) == '0)))
        hit = w;
    end
    r.found  = 1'b0;
    r.value  = '1;
    r.status = ST_OK;
    if (hit != WAYS) begin
      r.found = 1'b1;
      r.value = {1'b0, val_mem[base + hit]};
      if (kind == KIND_PUT) val_mem[base + hit] = new_val;
    end else if (kind == KIND_PUT) begin
      if (used < WAYS) begin
        key_mem[base + used] = key;
        val_mem[base + used] = new_val;
        fill[bkt]            = used + 1;
        r.status             = ST_NEW;
      end else begin
        r.status = ST_FULL;
      end
    end
    return r;
  endfunction

  // Retire results against the oldest expectation, then track config and requests
  always @(posedge clk_i) begin : watch
    reply_t got, want;
    if (!rst_ni) begin
      taxa_reg = TAXA_W'(KEY_BITS);
      foreach (fill[b]) fill[b] = 0;
      replies_due.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got.found  = rsp_tuser_i[0];
        got.status = rsp_tuser_i[2:1];
        got.value  = rsp_data_i;
        if (replies_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", rsp_data_i, 0);
        end else begin
          want = replies_due.pop_front();
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.value !== want.value) report_mismatch("stored_value", got.value, want.value);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        end
      end
      if (cfg_valid_i && cfg_ready_i) taxa_reg = cfg_data_i;
      if (req_valid_i && req_ready_i)
        replies_due.push_back(predict_reply(req_kind_i, req_data_i[KEY_BITS-1:0],
                                            req_data_i[KEY_BITS +: VAL_W]));
    end
    pending_o    <= replies_due.size();
    mismatches_o <= mismatches;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bht_pkg::*;

  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [TAXA_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // key, new_value, zero pad
  logic                   s_axis_tuser  = 1'b0;  // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // stored_value
  logic [OUT_TUSER_W-1:0] m_axis_tuser;  // found, status

  int unsigned pending;
  int unsigned mismatches;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 86;

  logic [KEY_BITS-1:0] put_keys [$];

  always #4 clk_i = ~clk_i;

  bipartition_hash_table uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  split_table_monitor monitor_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_kind_i  (s_axis_tuser),
    .rsp_valid_i (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),
    .rsp_tuser_i (m_axis_tuser),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold a request until it is taken; idle beforehand at random
  task automatic issue_request(input logic kind, input logic [KEY_BITS-1:0] key,
                               input logic [VAL_W-1:0] new_val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_TDATA_W - KEY_BITS - VAL_W){1'b0}}, new_val, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every result is back and the block is quiet
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_taxa(input logic [TAXA_W-1:0] taxa);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= taxa;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [KEY_BITS-1:0] taxa_mask(input int unsigned n);
    return (n >= KEY_BITS) ? '1 : ((KEY_BITS'(1) << n) - KEY_BITS'(1));
  endfunction

  // Random split with exactly half of the n taxa on each side
  function automatic logic [KEY_BITS-1:0] balanced_key(input int unsigned n);
    logic [KEY_BITS-1:0] key;
    logic bit_i;
    int unsigned j;
    key = (KEY_BITS'(1) << (n / 2)) - KEY_BITS'(1);
    for (int unsigned i = n - 1; i > 0; i--) begin
      j      = $urandom_range(i);
      bit_i  = key[i];
      key[i] = key[j];
      key[j] = bit_i;
    end
    return key;
  endfunction

  // Revisit stored splits (as is or complemented), add fresh and tied ones, some noise
  task automatic random_request(input int unsigned n);
    logic [KEY_BITS-1:0] mask, key, noise;
    logic [VAL_W-1:0] new_val;
    logic kind;
    int unsigned pick;
    mask    = taxa_mask(n);
    noise   = {$urandom, $urandom};
    new_val = VAL_W'($urandom);
    kind    = 1'($urandom);
    pick    = $urandom_range(99);
    if (pick < 15) begin
      key = noise;
    end else if (pick < 50 && put_keys.size() != 0) begin
      key = put_keys[$urandom_range(put_keys.size() - 1)];
      if ($urandom_range(1) == 1) key = ~key;
      if ($urandom_range(9) < 3) key = (key & mask) | (noise & ~mask);
    end else begin
      if (pick < 70 && n != 0 && n % 2 == 0) key = balanced_key(n) | (noise & ~mask);
      else key = noise;
      kind = ($urandom_range(9) < 8) ? KIND_PUT : KIND_LOOKUP;
      if (kind == KIND_PUT) begin
        put_keys.push_back(key);
        if (put_keys.size() > 48) void'(put_keys.pop_front());
      end
    end
    issue_request(kind, key, new_val);
  endtask

  initial begin
    int unsigned taxa_plan [PHASES] = '{9, 1, 6, 0, 64, 127, 12, 65, 30};
    int unsigned live_taxa;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at the reset taxa count: empty table, complements, tied splits
    // filling one bucket past its ways, extreme keys and values
    issue_request(KIND_LOOKUP, 64'h0, 31'h0);
    issue_request(KIND_PUT,    64'h0, 31'h0);
    issue_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 31'h1234_5678);
    issue_request(KIND_PUT,    64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
    issue_request(KIND_LOOKUP, 64'h0, 31'h0);
    issue_request(KIND_PUT,    64'hAAAA_AAAA_AAAA_AAAA, 31'h5555_5555);
    issue_request(KIND_PUT,    64'h0000_0000_FFFF_FFFF, 31'h2AAA_AAAA);
    issue_request(KIND_PUT,    64'hFFFF_0000_FFFF_0000, 31'h1);
    issue_request(KIND_PUT,    64'hF0F0_F0F0_F0F0_F0F0, 31'h2);
    issue_request(KIND_PUT,    64'hCCCC_CCCC_CCCC_CCCC, 31'h3);
    issue_request(KIND_LOOKUP, 64'hF0F0_F0F0_F0F0_F0F0, 31'h0);
    issue_request(KIND_PUT,    64'h5555_5555_5555_5555, 31'h7FFF_FFFE);
    issue_request(KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 31'h0);
    issue_request(KIND_LOOKUP, 64'h8000_0000_0000_0000, 31'h7FFF_FFFF);
    issue_request(KIND_PUT,    64'h8000_0000_0000_0000, 31'h1);
    issue_request(KIND_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 31'h0);
    issue_request(KIND_PUT,    64'h0000_0000_0000_0001, 31'h4000_0000);
    issue_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 31'h0);
    issue_request(KIND_LOOKUP, 64'h00FF_00FF_00FF_00FF, 31'h0);
    issue_request(KIND_PUT,    64'h0000_0000_FFFF_FFFF, 31'h7FFF_FFFF);

    // Random phases, each under its own taxa count, with the stall mix changed twice along the way
    for (int unsigned p = 0; p < PHASES; p++) begin
      drain_replies();
      if (p == 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 33;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_taxa(TAXA_W'(taxa_plan[p]));
      live_taxa = (taxa_plan[p] > KEY_BITS) ? KEY_BITS : taxa_plan[p];
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) random_request(live_taxa);
    end

    drain_replies();
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bht_pkg.sv
sv/bht_hash.sv
sv/bht_fill.sv
sv/bht_entry.sv
sv/bipartition_hash_table.sv
verif/split_table_monitor.sv
verif/testbench.sv
